FILE: rtl/core/dps_pkg.sv
package dps_pkg;

   localparam logic REQ_SUBMIT = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   localparam logic [2:0] ST_ACCEPTED  = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_BAD       = 3'd2;
   localparam logic [2:0] ST_TICK_IDLE = 3'd3;
   localparam logic [2:0] ST_RAN       = 3'd4;
   localparam logic [2:0] ST_FINISHED  = 3'd5;

   localparam logic [7:0]  STEP_RESET = 8'd2;
   localparam logic [15:0] CLOCK_MAX  = 16'hFFFF;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_SUBMIT,
      OP_TICK_START,
      OP_POP_SHIFT,
      OP_POP_END,
      OP_ADM_INS,
      OP_ADM_KEEP,
      OP_ADM_END,
      OP_INS_SHIFT,
      OP_INS_PLACE,
      OP_IDLE_RES,
      OP_RUN_HEAD,
      OP_AGE_STEP,
      OP_AGE_END,
      OP_PUBLISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic had_runner;
      logic idx_lt_rc;
      logic idx_lt_pc;
      logic adm_match;
      logic ins_shift;
      logic ready_empty;
   } dp_sts_type;

   function automatic logic signed [15:0] sat_add(input logic signed [15:0] p,
                                                  input logic [7:0] s);
      logic [16:0] sum;
      sum = {p[15], p} + {9'd0, s};
      if (sum[16] != sum[15]) begin
         return 16'sh7FFF;
      end
      return sum[15:0];
   endfunction

   function automatic logic signed [15:0] sat_sub(input logic signed [15:0] p,
                                                  input logic [7:0] s);
      logic [16:0] diff;
      diff = {p[15], p} - {9'd0, s};
      if (diff[16] != diff[15]) begin
         return 16'sh8000;
      end
      return diff[15:0];
   endfunction

endpackage

FILE: rtl/core/dps_datapath.sv
module dps_datapath #(
   parameter int MAX_PROCS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dps_pkg::dp_cmd_type  cmd,
   output dps_pkg::dp_sts_type  sts,
   input  logic                 csr_valid,
   input  logic [7:0]           csr_priority_step,
   input  logic [7:0]           req_process_id,
   input  logic [15:0]          req_arrival_time,
   input  logic [15:0]          req_service_time,
   input  logic signed [15:0]   req_initial_priority,
   output logic [2:0]           rsp_status,
   output logic [7:0]           rsp_run_id,
   output logic [15:0]          rsp_tick_time,
   output logic [16:0]          rsp_finish_time,
   output logic [16:0]          rsp_turnaround
);
   import dps_pkg::*;

   localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CW = $clog2(MAX_PROCS + 1);

   logic [MAX_PROCS-1:0]  valid_ff;
   logic [7:0]            id_mem      [MAX_PROCS];
   logic [15:0]           arr_mem     [MAX_PROCS];
   logic [15:0]           rem_mem     [MAX_PROCS];
   logic signed [15:0]    prio_mem    [MAX_PROCS];
   logic [IW-1:0]         po_mem      [MAX_PROCS];
   logic [IW-1:0]         ro_mem      [MAX_PROCS];

   logic [CW-1:0]  pc_ff, rc_ff, idx_ff, k_ff, ins_pos_ff;
   logic [IW-1:0]  ins_slot_ff, held_ff;
   logic           runner_held_ff, had_runner_ff, finish_ff;
   logic [15:0]    clock_ff;
   logic [7:0]     step_ff;

   logic [2:0]     res_status_ff;
   logic [7:0]     res_run_id_ff;
   logic [15:0]    res_tick_ff;
   logic [16:0]    res_fin_ff, res_turn_ff;
   logic [2:0]     out_status_ff;
   logic [7:0]     out_run_id_ff;
   logic [15:0]    out_tick_ff;
   logic [16:0]    out_fin_ff, out_turn_ff;

   logic [IW-1:0]  free_slot;
   logic           have_free;
   logic [IW-1:0]  idx_lo, idx_prev, ins_lo, ins_prev_pos;
   logic [IW-1:0]  po_s, ins_prev, head, age_slot;
   logic           sub_bad, sub_full;
   logic [16:0]    fin_val;

   always_comb begin
      free_slot = '0;
      have_free = 1'b0;
      for (int i = MAX_PROCS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot = IW'(i);
            have_free = 1'b1;
         end
      end
   end

   assign idx_lo       = idx_ff[IW-1:0];
   assign idx_prev     = idx_lo - IW'(1);
   assign ins_lo       = ins_pos_ff[IW-1:0];
   assign ins_prev_pos = ins_lo - IW'(1);
   assign po_s         = po_mem[idx_lo];
   assign ins_prev     = ro_mem[ins_prev_pos];
   assign head         = ro_mem[0];
   assign age_slot     = ro_mem[idx_lo];
   assign fin_val      = {1'b0, clock_ff} + 17'd1;

   assign sub_bad  = (req_service_time == 16'd0) || (req_arrival_time < clock_ff);
   assign sub_full = !have_free || (pc_ff >= CW'(MAX_PROCS));

   assign sts.had_runner  = had_runner_ff;
   assign sts.idx_lt_rc   = idx_ff < rc_ff;
   assign sts.idx_lt_pc   = idx_ff < pc_ff;
   assign sts.adm_match   = arr_mem[po_s] == clock_ff;
   assign sts.ins_shift   = (ins_pos_ff != '0) && (prio_mem[ins_slot_ff] < prio_mem[ins_prev]);
   assign sts.ready_empty = rc_ff == '0;

   // Control state of the table and the tick sequence.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         pc_ff          <= '0;
         rc_ff          <= '0;
         idx_ff         <= '0;
         k_ff           <= '0;
         ins_pos_ff     <= '0;
         runner_held_ff <= 1'b0;
         had_runner_ff  <= 1'b0;
         finish_ff      <= 1'b0;
         clock_ff       <= '0;
         step_ff        <= STEP_RESET;
      end else begin
         if (csr_valid) begin
            step_ff <= csr_priority_step;
         end
         case (cmd.op)
            OP_SUBMIT: begin
               if (!sub_bad && !sub_full) begin
                  valid_ff[free_slot] <= 1'b1;
                  pc_ff               <= pc_ff + CW'(1);
               end
            end
            OP_TICK_START: begin
               had_runner_ff  <= runner_held_ff && (rc_ff != '0);
               runner_held_ff <= 1'b0;
               idx_ff         <= CW'(1);
            end
            OP_POP_SHIFT: idx_ff <= idx_ff + CW'(1);
            OP_POP_END: begin
               if (had_runner_ff) begin
                  rc_ff <= rc_ff - CW'(1);
               end
               idx_ff <= '0;
               k_ff   <= '0;
            end
            OP_ADM_INS: begin
               ins_pos_ff <= rc_ff;
               idx_ff     <= idx_ff + CW'(1);
            end
            OP_ADM_KEEP: begin
               k_ff   <= k_ff + CW'(1);
               idx_ff <= idx_ff + CW'(1);
            end
            OP_ADM_END: begin
               pc_ff      <= k_ff;
               ins_pos_ff <= rc_ff;
            end
            OP_INS_SHIFT: ins_pos_ff <= ins_pos_ff - CW'(1);
            OP_INS_PLACE: rc_ff <= rc_ff + CW'(1);
            OP_IDLE_RES: begin
               if (clock_ff != CLOCK_MAX) begin
                  clock_ff <= clock_ff + 16'd1;
               end
            end
            OP_RUN_HEAD: begin
               idx_ff <= CW'(1);
               if (rem_mem[head] == 16'd1) begin
                  finish_ff      <= 1'b1;
                  valid_ff[head] <= 1'b0;
               end else begin
                  finish_ff      <= 1'b0;
                  runner_held_ff <= 1'b1;
               end
            end
            OP_AGE_STEP: idx_ff <= idx_ff + CW'(1);
            OP_AGE_END: begin
               if (finish_ff) begin
                  rc_ff <= rc_ff - CW'(1);
               end
               if (clock_ff != CLOCK_MAX) begin
                  clock_ff <= clock_ff + 16'd1;
               end
            end
            default: ;
         endcase
      end
   end

   // Table contents, list order and result registers.
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_SUBMIT: begin
            if (!sub_bad && !sub_full) begin
               id_mem[free_slot]        <= req_process_id;
               arr_mem[free_slot]       <= req_arrival_time;
               rem_mem[free_slot]       <= req_service_time;
               prio_mem[free_slot]      <= req_initial_priority;
               po_mem[pc_ff[IW-1:0]]    <= free_slot;
            end
            res_status_ff <= sub_bad ? ST_BAD : (sub_full ? ST_FULL : ST_ACCEPTED);
            res_run_id_ff <= '0;
            res_tick_ff   <= clock_ff;
            res_fin_ff    <= '0;
            res_turn_ff   <= '0;
         end
         OP_TICK_START: begin
            held_ff       <= head;
            res_run_id_ff <= '0;
            res_tick_ff   <= clock_ff;
            res_fin_ff    <= '0;
            res_turn_ff   <= '0;
         end
         OP_POP_SHIFT: ro_mem[idx_prev] <= age_slot;
         OP_ADM_INS:   ins_slot_ff <= po_s;
         OP_ADM_KEEP:  po_mem[k_ff[IW-1:0]] <= po_s;
         OP_ADM_END:   ins_slot_ff <= held_ff;
         OP_INS_SHIFT: ro_mem[ins_lo] <= ins_prev;
         OP_INS_PLACE: ro_mem[ins_lo] <= ins_slot_ff;
         OP_IDLE_RES:  res_status_ff <= ST_TICK_IDLE;
         OP_RUN_HEAD: begin
            res_run_id_ff  <= id_mem[head];
            rem_mem[head]  <= rem_mem[head] - 16'd1;
            prio_mem[head] <= sat_add(prio_mem[head], step_ff);
            if (rem_mem[head] == 16'd1) begin
               res_status_ff <= ST_FINISHED;
               res_fin_ff    <= fin_val;
               res_turn_ff   <= fin_val - {1'b0, arr_mem[head]};
            end else begin
               res_status_ff <= ST_RAN;
            end
         end
         OP_AGE_STEP: begin
            prio_mem[age_slot] <= sat_sub(prio_mem[age_slot], step_ff);
            if (finish_ff) begin
               ro_mem[idx_prev] <= age_slot;
            end
         end
         OP_PUBLISH: begin
            out_status_ff <= res_status_ff;
            out_run_id_ff <= res_run_id_ff;
            out_tick_ff   <= res_tick_ff;
            out_fin_ff    <= res_fin_ff;
            out_turn_ff   <= res_turn_ff;
         end
         default: ;
      endcase
   end

   assign rsp_status      = out_status_ff;
   assign rsp_run_id      = out_run_id_ff;
   assign rsp_tick_time   = out_tick_ff;
   assign rsp_finish_time = out_fin_ff;
   assign rsp_turnaround  = out_turn_ff;

   // Every live slot sits in exactly one of the two lists between items.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_TICK_START) |-> ($countones(valid_ff) == int'(rc_ff) + int'(pc_ff)))
      else $error("slot table and list counts disagree");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_RUN_HEAD) |-> (rc_ff != '0))
      else $error("head run with an empty ready list");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_INS_PLACE) |-> (rc_ff < CW'(MAX_PROCS)))
      else $error("ready list overflow");

endmodule

FILE: rtl/core/dps_controller.sv
module dps_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_type,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output dps_pkg::dp_cmd_type  cmd,
   input  dps_pkg::dp_sts_type  sts
);
   import dps_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_POP, S_ADM, S_INS, S_INSH, S_RUN, S_AGE, S_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_type == REQ_TICK) begin
                  cmd.op   = OP_TICK_START;
                  state_in = S_POP;
               end else begin
                  cmd.op   = OP_SUBMIT;
                  state_in = S_WAIT;
               end
            end
         end
         S_POP: begin
            if (sts.had_runner && sts.idx_lt_rc) begin
               cmd.op = OP_POP_SHIFT;
            end else begin
               cmd.op   = OP_POP_END;
               state_in = S_ADM;
            end
         end
         S_ADM: begin
            if (sts.idx_lt_pc) begin
               if (sts.adm_match) begin
                  cmd.op   = OP_ADM_INS;
                  state_in = S_INS;
               end else begin
                  cmd.op = OP_ADM_KEEP;
               end
            end else begin
               cmd.op   = OP_ADM_END;
               state_in = sts.had_runner ? S_INSH : S_RUN;
            end
         end
         S_INS, S_INSH: begin
            if (sts.ins_shift) begin
               cmd.op = OP_INS_SHIFT;
            end else begin
               cmd.op   = OP_INS_PLACE;
               state_in = (state_ff == S_INS) ? S_ADM : S_RUN;
            end
         end
         S_RUN: begin
            if (sts.ready_empty) begin
               cmd.op   = OP_IDLE_RES;
               state_in = S_WAIT;
            end else begin
               cmd.op   = OP_RUN_HEAD;
               state_in = S_AGE;
            end
         end
         S_AGE: begin
            if (sts.idx_lt_rc) begin
               cmd.op = OP_AGE_STEP;
            end else begin
               cmd.op   = OP_AGE_END;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   // A tick transfer always enters the tick sequence before its result is published.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_type == REQ_TICK) |=> (state_ff == S_POP))
      else $error("tick transfer did not start the tick sequence");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_PUBLISH) |=> rsp_valid_ff)
      else $error("published result not presented");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT && rsp_valid_ff && !rsp_ready) |=> (state_ff == S_WAIT))
      else $error("result overwritten while the previous one waits");

endmodule

FILE: rtl/core/dynamic_priority_scheduler.sv
// Dynamic-priority process scheduler with aging. A submit transfer places a process in
// a table of MAX_PROCS slots; its result is published once the previous one is taken.
// A tick transfer walks a single sequencer through the lists one entry per cycle: it
// pops the previous runner off the ready list, moves arrivals from the pending list into
// the ready list, puts arrivals and the previous runner into priority order by shifting,
// runs the head of the ready list and ages the other ready entries.
// The priority_step register is written through the csr_ channel, which is always ready,
// and should be written only while no request is in flight. A finished result waits in
// an output register; the next request is taken while it waits.
module dynamic_priority_scheduler #(
   parameter int MAX_PROCS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_priority_step,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_type,
   input  logic [7:0]         req_process_id,
   input  logic [15:0]        req_arrival_time,
   input  logic [15:0]        req_service_time,
   input  logic signed [15:0] req_initial_priority,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [7:0]         rsp_run_id,
   output logic [15:0]        rsp_tick_time,
   output logic [16:0]        rsp_finish_time,
   output logic [16:0]        rsp_turnaround
);
   import dps_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   assign csr_ready = 1'b1;

   dps_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   dps_datapath #(.MAX_PROCS(MAX_PROCS)) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .csr_valid            (csr_valid),
      .csr_priority_step    (csr_priority_step),
      .req_process_id       (req_process_id),
      .req_arrival_time     (req_arrival_time),
      .req_service_time     (req_service_time),
      .req_initial_priority (req_initial_priority),
      .rsp_status           (rsp_status),
      .rsp_run_id           (rsp_run_id),
      .rsp_tick_time        (rsp_tick_time),
      .rsp_finish_time      (rsp_finish_time),
      .rsp_turnaround       (rsp_turnaround)
   );

endmodule

FILE: dv/dynamic_priority_scheduler_tb.sv
`timescale 1ns / 100ps

module dynamic_priority_scheduler_tb;
   import dps_pkg::*;

   localparam int NPROC = 16;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  run_id;
      logic [15:0] tick_time;
      logic [16:0] finish_time;
      logic [16:0] turnaround;
   } sched_rsp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [7:0]         csr_priority_step = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_type = REQ_SUBMIT;
   logic [7:0]         req_process_id = '0;
   logic [15:0]        req_arrival_time = '0;
   logic [15:0]        req_service_time = '0;
   logic signed [15:0] req_initial_priority = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_status;
   logic [7:0]         rsp_run_id;
   logic [15:0]        rsp_tick_time;
   logic [16:0]        rsp_finish_time;
   logic [16:0]        rsp_turnaround;

   dynamic_priority_scheduler u_dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_priority_step(csr_priority_step),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_process_id(req_process_id), .req_arrival_time(req_arrival_time),
      .req_service_time(req_service_time), .req_initial_priority(req_initial_priority),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_run_id(rsp_run_id), .rsp_tick_time(rsp_tick_time),
      .rsp_finish_time(rsp_finish_time), .rsp_turnaround(rsp_turnaround)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Scheduler image kept by the testbench.
   logic [7:0]  step_reg;
   logic        tbl_valid [NPROC];
   logic [7:0]  tbl_id [NPROC];
   logic [15:0] tbl_arrival [NPROC];
   logic [15:0] tbl_remaining [NPROC];
   int          tbl_prio [NPROC];
   int          pend_list [NPROC];
   int          pend_cnt;
   int          rdy_list [NPROC];
   int          rdy_cnt;
   logic        runner_live;
   logic [15:0] sched_clock;

   sched_rsp_type expected_rsp_q[$];
   int          fail_count = 0;
   logic        calm = 1'b0;

   function automatic int clamp16(input int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // New entries go behind every entry with an equal or smaller priority value.
   function automatic void ready_place(input int s);
      int pos;
      pos = 0;
      if (rdy_cnt >= NPROC) return;
      while (pos < rdy_cnt && !(tbl_prio[s] < tbl_prio[rdy_list[pos]])) pos++;
      for (int i = rdy_cnt; i > pos; i--) rdy_list[i] = rdy_list[i - 1];
      rdy_list[pos] = s;
      rdy_cnt++;
   endfunction

   function automatic sched_rsp_type schedule_step(input logic kind, input logic [7:0] pid,
                                                   input logic [15:0] arr,
                                                   input logic [15:0] svc,
                                                   input logic signed [15:0] pr);
      sched_rsp_type r;
      int free_slot, held, k, h;
      logic had;
      r = '0;
      r.tick_time = sched_clock;
      if (kind == REQ_SUBMIT) begin
         free_slot = NPROC;
         for (int i = NPROC - 1; i >= 0; i--) if (!tbl_valid[i]) free_slot = i;
         if (svc == 0 || arr < sched_clock) begin
            r.status = ST_BAD;
         end else if (free_slot >= NPROC || pend_cnt >= NPROC) begin
            r.status = ST_FULL;
         end else begin
            tbl_valid[free_slot] = 1'b1;
            tbl_id[free_slot] = pid;
            tbl_arrival[free_slot] = arr;
            tbl_remaining[free_slot] = svc;
            tbl_prio[free_slot] = int'(pr);
            pend_list[pend_cnt] = free_slot;
            pend_cnt++;
            r.status = ST_ACCEPTED;
         end
      end else begin
         had = 1'b0;
         held = 0;
         if (runner_live && rdy_cnt > 0) begin
            held = rdy_list[0];
            had = 1'b1;
            for (int i = 1; i < rdy_cnt; i++) rdy_list[i - 1] = rdy_list[i];
            rdy_cnt--;
         end
         runner_live = 1'b0;
         k = 0;
         for (int i = 0; i < pend_cnt; i++) begin
            if (tbl_arrival[pend_list[i]] == sched_clock) begin
               ready_place(pend_list[i]);
            end else begin
               pend_list[k] = pend_list[i];
               k++;
            end
         end
         pend_cnt = k;
         if (had) ready_place(held);
         if (rdy_cnt == 0) begin
            r.status = ST_TICK_IDLE;
         end else begin
            h = rdy_list[0];
            r.run_id = tbl_id[h];
            tbl_remaining[h] = tbl_remaining[h] - 16'd1;
            tbl_prio[h] = clamp16(tbl_prio[h] + int'(step_reg));
            for (int i = 1; i < rdy_cnt; i++)
               tbl_prio[rdy_list[i]] = clamp16(tbl_prio[rdy_list[i]] - int'(step_reg));
            if (tbl_remaining[h] == 0) begin
               r.finish_time = {1'b0, sched_clock} + 17'd1;
               r.turnaround = r.finish_time - {1'b0, tbl_arrival[h]};
               tbl_valid[h] = 1'b0;
               for (int i = 1; i < rdy_cnt; i++) rdy_list[i - 1] = rdy_list[i];
               rdy_cnt--;
               r.status = ST_FINISHED;
            end else begin
               runner_live = 1'b1;
               r.status = ST_RAN;
            end
         end
         if (sched_clock != CLOCK_MAX) sched_clock = sched_clock + 16'd1;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 38);
   end

   always @(posedge clock) begin
      sched_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            $error("unexpected result transfer, status %0d", rsp_status);
            fail_count++;
         end else begin
            e = expected_rsp_q.pop_front();
            if (rsp_status !== e.status) begin
               $error("status: expected %0d, actual %0d", e.status, rsp_status);
               fail_count++;
            end
            if (rsp_run_id !== e.run_id) begin
               $error("run_id: expected %0d, actual %0d", e.run_id, rsp_run_id);
               fail_count++;
            end
            if (rsp_tick_time !== e.tick_time) begin
               $error("tick_time: expected %0d, actual %0d", e.tick_time, rsp_tick_time);
               fail_count++;
            end
            if (rsp_finish_time !== e.finish_time) begin
               $error("finish_time: expected %0d, actual %0d", e.finish_time,
                      rsp_finish_time);
               fail_count++;
            end
            if (rsp_turnaround !== e.turnaround) begin
               $error("turnaround: expected %0d, actual %0d", e.turnaround, rsp_turnaround);
               fail_count++;
            end
         end
      end
   end

   task automatic send_item(input logic kind, input logic [7:0] pid, input logic [15:0] arr,
                            input logic [15:0] svc, input logic signed [15:0] pr);
      req_valid <= 1'b1;
      req_type <= kind;
      req_process_id <= pid;
      req_arrival_time <= arr;
      req_service_time <= svc;
      req_initial_priority <= pr;
      do @(posedge clock); while (!req_ready);
      expected_rsp_q.push_back(schedule_step(kind, pid, arr, svc, pr));
      if (!calm && $urandom_range(0, 99) < 38) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic tick();
      send_item(REQ_TICK, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // Waits for every outstanding result, then lets the sequencer settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_step(input logic [7:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_priority_step <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      step_reg = value;
   endtask

   task automatic random_items(input int count);
      logic [15:0] arr, svc;
      logic signed [15:0] pr;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 55) begin
            tick();
         end else begin
            arr = sched_clock + 16'($urandom_range(0, 6));
            svc = 16'($urandom_range(1, 8));
            pr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40) - 20);
            if ($urandom_range(0, 99) < 8) begin
               if (sched_clock != 0 && $urandom_range(0, 1)) arr = sched_clock - 16'd1;
               else svc = '0;
            end
            send_item(REQ_SUBMIT, 8'($urandom), arr, svc, pr);
         end
      end
   endtask

   task automatic test_directed();
      send_item(REQ_SUBMIT, 8'd1, 16'd0, 16'd0, 16'sd0);
      tick();
      send_item(REQ_SUBMIT, 8'd2, 16'd0, 16'd3, 16'sd0);
      send_item(REQ_SUBMIT, 8'hFF, 16'd1, 16'd2, 16'sh7FFF);
      send_item(REQ_SUBMIT, 8'h00, 16'd1, 16'd1, 16'sh8000);
      // A process that never arrives holds one slot for the rest of the run.
      send_item(REQ_SUBMIT, 8'hAA, 16'hFFFF, 16'hFFFF, 16'sh5555);
      repeat (4) tick();
   endtask

   task automatic test_table_full();
      for (int i = 0; i < 16; i++)
         send_item(REQ_SUBMIT, 8'(i + 16), sched_clock + 16'd2, 16'd1, 16'(i * 7 - 50));
      repeat (20) tick();
   endtask

   task automatic test_step_extremes();
      write_step(8'd255);
      random_items(150);
      write_step(8'd0);
      random_items(150);
   endtask

   task automatic test_random();
      write_step(8'($urandom));
      calm = 1'b1;
      random_items(300);
      calm = 1'b0;
      random_items(600);
      // The sender holds off here until every result is back.
      drain();
      write_step(8'd2);
      random_items(600);
   endtask

   initial begin
      step_reg = STEP_RESET;
      for (int i = 0; i < NPROC; i++) tbl_valid[i] = 1'b0;
      pend_cnt = 0;
      rdy_cnt = 0;
      runner_live = 1'b0;
      sched_clock = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_table_full();
      test_step_extremes();
      test_random();
      drain();
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/dps_pkg.sv
rtl/core/dps_datapath.sv
rtl/core/dps_controller.sv
rtl/core/dynamic_priority_scheduler.sv
dv/dynamic_priority_scheduler_tb.sv
